// File: rtl/udpd_pkg.sv
// udpd_pkg: command and result types, action and status codes
// for the udp port dispatch table; no dependencies
package udpd_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  l3_kind;
        logic [7:0]  protocol;
        logic [15:0] key_port;
        logic [15:0] alias_port;
        logic [15:0] next_edge;
    } t_cmd;

    typedef struct packed {
        logic [15:0] edge_res;
        logic [2:0]  status;
    } t_result;

    localparam logic [1:0] ACT_CLASSIFY = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_ALIAS    = 2'd2;
    localparam logic [1:0] ACT_UNALIAS  = 2'd3;

    localparam logic [1:0] L3_IPV4 = 2'd1;
    localparam logic [1:0] L3_IPV6 = 2'd2;

    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] EDGE_MANAGEMENT = 16'd0;
    localparam logic [15:0] EDGE_BAD_PROTO  = 16'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_AVAIL = 3'd1;
    localparam logic [2:0] ST_IN_USE    = 3'd2;
    localparam logic [2:0] ST_ALREADY   = 3'd3;
    localparam logic [2:0] ST_BAD_PROTO = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

endpackage

// File: rtl/udp_port_dispatch_table.sv
// udp_port_dispatch_table: port-indexed edge and reference count tables
// held in two synchronous memories, one read and one write port each; depends on udpd_pkg
// results: classify, register and unalias are decided in S_RD, alias in S_DST
// after a second table read for the target; o_done is registered behind both
// a new transaction is taken only once the last one is through; busy covers the
// read-modify-write sequence on the table port
// reset: synchronous, clears control and then sweeps both tables to zero,
// one entry a cycle over all 2**PORT_BITS entries with busy high; results never stall
module udp_port_dispatch_table
    import udpd_pkg::*;
#(
    parameter int PORT_BITS  = 16,
    parameter int EDGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int DEPTH = 1 << PORT_BITS;

    // sequencer states
    localparam logic [1:0] S_CLR  = 2'd0;  // post-reset clearing sweep
    localparam logic [1:0] S_IDLE = 2'd1;  // waiting for a transaction
    localparam logic [1:0] S_RD   = 2'd2;  // first table read available
    localparam logic [1:0] S_DST  = 2'd3;  // alias target read available

    // table storage
    logic [EDGE_BITS-1:0]  edge_mem [DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem  [DEPTH];

    logic [1:0]            r_state, n_state;
    logic [PORT_BITS-1:0]  r_clr_addr;
    t_cmd                  r_cmd;
    logic [EDGE_BITS-1:0]  r_src_edge, n_src_edge;
    logic [EDGE_BITS-1:0]  r_edge_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic                  accept;
    logic [PORT_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [PORT_BITS-1:0]  wr_addr;
    logic [EDGE_BITS-1:0]  wr_edge;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  is_udp;
    logic                  cnt_full;
    logic [EDGE_BITS-1:0]  new_edge;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // first read goes out on the accepting edge, straight from the command
    always_comb begin
        if (r_state == S_IDLE) begin
            if (i_cmd.action == ACT_UNALIAS) begin
                rd_addr = i_cmd.alias_port[PORT_BITS-1:0];
            end else begin
                rd_addr = i_cmd.key_port[PORT_BITS-1:0];
            end
        end else begin
            rd_addr = r_cmd.alias_port[PORT_BITS-1:0];
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_edge_q <= edge_mem[rd_addr];
        r_cnt_q  <= cnt_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            edge_mem[wr_addr] <= wr_edge;
            cnt_mem[wr_addr]  <= wr_cnt;
        end
    end

    assign is_udp   = (r_cmd.protocol == PROTO_UDP);
    assign cnt_full = &r_cnt_q;
    assign new_edge = r_cmd.next_edge[EDGE_BITS-1:0];
    assign cnt_inc  = r_cnt_q + COUNT_BITS'(1);
    assign cnt_dec  = r_cnt_q - COUNT_BITS'(1);

    // sequencer and read-modify-write decisions; writes land at the end of
    // the last busy cycle, so the next transaction's read sees them
    always_comb begin
        n_state    = r_state;
        n_src_edge = r_src_edge;
        n_done     = 1'b0;
        n_result   = '0;
        wr_en      = 1'b0;
        wr_addr    = r_cmd.key_port[PORT_BITS-1:0];
        wr_edge    = '0;
        wr_cnt     = '0;

        unique case (r_state)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (r_cmd.action)
                    ACT_CLASSIFY: begin
                        if (r_cmd.l3_kind != L3_IPV4 && r_cmd.l3_kind != L3_IPV6) begin
                            n_result.edge_res = EDGE_BAD_PROTO;
                        end else if (is_udp) begin
                            n_result.edge_res = 16'(r_edge_q);
                        end else begin
                            n_result.edge_res = EDGE_MANAGEMENT;
                        end
                    end
                    ACT_REGISTER: begin
                        priority if (!is_udp) begin
                            n_result.status = ST_BAD_PROTO;
                        end else if (r_edge_q != '0) begin
                            n_result.status = ST_ALREADY;
                        end else if (new_edge == EDGE_BITS'(EDGE_MANAGEMENT) ||
                                     new_edge == EDGE_BITS'(EDGE_BAD_PROTO)) begin
                            n_result.status = ST_NOT_AVAIL;
                        end else if (cnt_full) begin
                            n_result.status = ST_FULL;
                        end else begin
                            n_result.status = ST_OK;
                            wr_en   = 1'b1;
                            wr_edge = new_edge;
                            wr_cnt  = cnt_inc;
                        end
                    end
                    ACT_ALIAS: begin
                        priority if (!is_udp) begin
                            n_result.status = ST_BAD_PROTO;
                        end else if (r_edge_q == '0) begin
                            n_result.status = ST_NOT_AVAIL;
                        end else begin
                            // source is live, go read the target entry
                            n_done     = 1'b0;
                            n_state    = S_DST;
                            n_src_edge = r_edge_q;
                        end
                    end
                    ACT_UNALIAS: begin
                        wr_addr = r_cmd.alias_port[PORT_BITS-1:0];
                        priority if (!is_udp) begin
                            n_result.status = ST_BAD_PROTO;
                        end else if (r_edge_q == '0 || r_cnt_q == '0) begin
                            n_result.status = ST_NOT_AVAIL;
                        end else begin
                            n_result.status = ST_OK;
                            wr_en  = 1'b1;
                            wr_cnt = cnt_dec;
                            // last reference frees the entry
                            wr_edge = (cnt_dec == '0) ? '0 : r_edge_q;
                        end
                    end
                    default: begin
                        n_result = '0;
                    end
                endcase
            end
            S_DST: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                wr_addr = r_cmd.alias_port[PORT_BITS-1:0];
                priority if (r_edge_q != '0 && r_edge_q != r_src_edge) begin
                    n_result.status = ST_IN_USE;
                end else if (cnt_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_result.status = ST_OK;
                    wr_en   = 1'b1;
                    wr_edge = r_src_edge;
                    wr_cnt  = cnt_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + PORT_BITS'(1);
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_src_edge <= n_src_edge;
        r_result   <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // a result strobe always comes with the block free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction always enters the read sequence, with busy high
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("transaction did not enter the read sequence");

    // only classify carries an edge, and classify always reports ok
    a_res_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.edge_res == EDGE_MANAGEMENT))
        else $error("edge and error status in one result");

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for udp_port_dispatch_table, with directed, self-alias and
// random command traffic checked against a scoreboard that models the dispatch tables
// depends on rtl/udpd_pkg.sv and rtl/udp_port_dispatch_table.sv
`timescale 1ns / 100ps

module tb_top;
    import udpd_pkg::*;

    // block configuration, matched to the instance below
    localparam int PORT_BITS  = 16;
    localparam int EDGE_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam logic [15:0] REF_COUNT_MAX = 16'((64'd1 << COUNT_BITS) - 1);

    // l3 kinds and protocols that the package leaves unnamed
    localparam logic [1:0] L3_NONE    = 2'd0;
    localparam logic [1:0] L3_UNKNOWN = 2'd3;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_ANY  = 8'd255;

    // port and edge that take a short run of self-aliases
    localparam logic [15:0] SELF_PORT = 16'hA5C3;
    localparam logic [15:0] SELF_EDGE = 16'h5A3C;
    localparam int          SELF_ALIASES = 8;

    localparam int RANDOM_ITEMS = 1425;
    localparam int POOL_SIZE    = 16;
    localparam int MAX_PRINTED  = 30;

    typedef struct {
        t_cmd    cmd;
        t_result want;
    } t_due;

    // models both tables and holds the replies still owed by the block
    class dispatch_scoreboard;
        bit [15:0] port_edge [0:65535];
        bit [15:0] port_refs [0:65535];
        t_due      replies_due[$];
        int        errors;
        int        checked;
        int        refused;
        int        act_seen[4];

        function automatic t_result dispatch(t_cmd c);
            t_result    r;
            logic [15:0] src_edge;
            logic [15:0] key;
            logic [15:0] alt;
            logic [15:0] nedge;
            key   = c.key_port   & 16'((64'd1 << PORT_BITS) - 1);
            alt   = c.alias_port & 16'((64'd1 << PORT_BITS) - 1);
            nedge = c.next_edge  & 16'((64'd1 << EDGE_BITS) - 1);
            r.edge_res = EDGE_MANAGEMENT;
            r.status   = ST_OK;
            case (c.action)
                ACT_CLASSIFY: begin
                    // anything not IPv4/IPv6 is bad protocol, non-udp goes to management
                    if (c.l3_kind != L3_IPV4 && c.l3_kind != L3_IPV6)
                        r.edge_res = EDGE_BAD_PROTO;
                    else if (c.protocol == PROTO_UDP)
                        r.edge_res = port_edge[key];
                end
                ACT_REGISTER: begin
                    if (c.protocol != PROTO_UDP)
                        r.status = ST_BAD_PROTO;
                    else if (port_edge[key] != EDGE_MANAGEMENT)
                        r.status = ST_ALREADY;
                    else if (nedge == EDGE_MANAGEMENT || nedge == EDGE_BAD_PROTO)
                        r.status = ST_NOT_AVAIL;
                    else if (port_refs[key] >= REF_COUNT_MAX)
                        r.status = ST_FULL;
                    else begin
                        port_edge[key] = nedge;
                        port_refs[key] = port_refs[key] + 16'd1;
                    end
                end
                ACT_ALIAS: begin
                    src_edge = port_edge[key];
                    if (c.protocol != PROTO_UDP)
                        r.status = ST_BAD_PROTO;
                    else if (src_edge == EDGE_MANAGEMENT)
                        r.status = ST_NOT_AVAIL;
                    else if (port_edge[alt] != EDGE_MANAGEMENT && port_edge[alt] != src_edge)
                        r.status = ST_IN_USE;
                    else if (port_refs[alt] >= REF_COUNT_MAX)
                        r.status = ST_FULL;
                    else begin
                        port_edge[alt] = src_edge;
                        port_refs[alt] = port_refs[alt] + 16'd1;
                    end
                end
                default: begin
                    if (c.protocol != PROTO_UDP)
                        r.status = ST_BAD_PROTO;
                    else if (port_edge[alt] == EDGE_MANAGEMENT || port_refs[alt] == 16'd0)
                        r.status = ST_NOT_AVAIL;
                    else begin
                        port_refs[alt] = port_refs[alt] - 16'd1;
                        if (port_refs[alt] == 16'd0)
                            port_edge[alt] = EDGE_MANAGEMENT;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_command(t_cmd c);
            t_due d;
            d.cmd  = c;
            d.want = dispatch(c);
            act_seen[c.action]++;
            if (d.want.status != ST_OK)
                refused++;
            replies_due.push_back(d);
        endfunction

        task report(string what, t_cmd c, logic [15:0] got, logic [15:0] want);
            if (errors < MAX_PRINTED)
                $display({"%0t: mismatch on %s: act %0d l3 %0d proto %0d key %h alias %h",
                          " next %h got %h want %h"},
                         $realtime, what, c.action, c.l3_kind, c.protocol, c.key_port,
                         c.alias_port, c.next_edge, got, want);
            errors++;
        endtask

        task check_result(t_result got);
            t_due d;
            checked++;
            if (replies_due.size() == 0) begin
                d.cmd = '0;
                report("unexpected result strobe", d.cmd, got.edge_res, 16'd0);
            end else begin
                d = replies_due.pop_front();
                if (got.edge_res !== d.want.edge_res)
                    report("edge_res", d.cmd, got.edge_res, d.want.edge_res);
                if (got.status !== d.want.status)
                    report("status", d.cmd, 16'(got.status), 16'(d.want.status));
            end
        endtask

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;

    dispatch_scoreboard sb;
    bit [15:0] port_pool [POOL_SIZE];

    udp_port_dispatch_table #(
        .PORT_BITS  (PORT_BITS),
        .EDGE_BITS  (EDGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watches both sides: a transaction is taken when start is high and busy low,
    // a result is taken on the one cycle that o_done marks
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result);
        if (i_rst_n && start && !busy)
            sb.note_command(i_cmd);
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // most ports come from a small pool so that entries get reused
    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 99) < 80)
            return port_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    function automatic t_cmd build_cmd(logic [1:0] act, logic [1:0] l3, logic [7:0] proto,
                                       logic [15:0] key, logic [15:0] alt,
                                       logic [15:0] nedge);
        t_cmd c;
        c.action     = act;
        c.l3_kind    = l3;
        c.protocol   = proto;
        c.key_port   = key;
        c.alias_port = alt;
        c.next_edge  = nedge;
        return c;
    endfunction

    // holds start high until the block takes the transaction, then idles for gap cycles;
    // with no gap, start stays high for the next call
    task send_cmd(t_cmd c, int gap);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding reply come back
    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_cmd c;
        bit   quiet;
        int   r;

        sb = new();
        start   <= 1'b0;
        i_cmd   <= '0;
        i_rst_n <= 1'b0;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            port_pool[i] = 16'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the table sweep after reset keeps busy high, send_cmd simply waits it out

        // directed: classify corner cases on empty tables
        send_cmd(build_cmd(ACT_CLASSIFY, L3_NONE, PROTO_UDP, 16'h0000, 16'hFFFF, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_UNKNOWN, PROTO_UDP, 16'hFFFF, 16'h0000,
                           16'hFFFF), pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_IPV4, PROTO_TCP, 16'h0000, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_IPV6, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));

        // register: wrong protocol, reserved edges, then a good one and a repeat
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_TCP, 16'hFFFF, 16'h0000, 16'h0002),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000,
                           EDGE_MANAGEMENT), pick_gap(0));
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000,
                           EDGE_BAD_PROTO), pick_gap(0));
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'hFFFF),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0003),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_IPV6, PROTO_ANY, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));

        // alias: wrong protocol, unknown source, good, target owned by another edge
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, 8'd0, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, PROTO_UDP, 16'h0000, 16'h0001, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV6, PROTO_UDP, 16'h0001, 16'h0000, 16'h0002),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, PROTO_UDP, 16'h0001, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));

        // unalias: wrong protocol, free entry, release twice down to free
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_ANY, 16'h0000, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_UDP, 16'h0000, 16'h0005, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_UDP, 16'hFFFF, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_CLASSIFY, L3_IPV6, PROTO_UDP, 16'h0000, 16'h0000, 16'h0000),
                 pick_gap(0));
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_UDP, 16'h0000, 16'h0000, 16'h0000),
                 pick_gap(0));

        // self-alias: register once, stack a run of aliases on the same port back to back,
        // release one and alias again
        send_cmd(build_cmd(ACT_REGISTER, L3_IPV4, PROTO_UDP, SELF_PORT, 16'h0000, SELF_EDGE),
                 0);
        for (int i = 0; i < SELF_ALIASES; i++)
            send_cmd(build_cmd(ACT_ALIAS, L3_IPV4, PROTO_UDP, SELF_PORT, SELF_PORT, 16'h0000),
                     0);
        send_cmd(build_cmd(ACT_UNALIAS, L3_IPV4, PROTO_UDP, 16'h0000, SELF_PORT, 16'h0000), 0);
        send_cmd(build_cmd(ACT_ALIAS, L3_IPV6, PROTO_UDP, SELF_PORT, SELF_PORT, 16'h0000),
                 pick_gap(0));

        // random traffic: mostly well-formed udp requests on a reused port pool,
        // some noise in l3 kind, protocol and edge; stretches with no idling at all
        quiet = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35)
                c.action = ACT_CLASSIFY;
            else if (r < 60)
                c.action = ACT_REGISTER;
            else if (r < 80)
                c.action = ACT_ALIAS;
            else
                c.action = ACT_UNALIAS;
            if ($urandom_range(0, 9) == 0)
                c.l3_kind = 2'($urandom);
            else
                c.l3_kind = $urandom_range(0, 1) ? L3_IPV4 : L3_IPV6;
            r = $urandom_range(0, 99);
            if (r < 85)
                c.protocol = PROTO_UDP;
            else if (r < 90)
                c.protocol = PROTO_TCP;
            else
                c.protocol = 8'($urandom);
            c.key_port   = pick_port();
            c.alias_port = pick_port();
            if ($urandom_range(0, 9) == 0)
                c.next_edge = 16'($urandom_range(0, 1));
            else
                c.next_edge = 16'($urandom_range(2, 65535));
            send_cmd(c, pick_gap(quiet));
            // halfway through, hold off until the block has answered everything
            if (i == RANDOM_ITEMS / 2)
                drain();
        end

        drain();
        repeat (4) @(posedge i_clk);

        $display("covered %0d classify, %0d register, %0d alias, %0d unalias transactions",
                 sb.act_seen[ACT_CLASSIFY], sb.act_seen[ACT_REGISTER],
                 sb.act_seen[ACT_ALIAS], sb.act_seen[ACT_UNALIAS]);
        $display("%0d results checked, %0d of them refusals, %0d mismatches",
                 sb.checked, sb.refused, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, well past the slowest legal run including the table sweep
    initial begin
        #4_000_000;
        $display("timeout: block stopped accepting or answering");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
